// ===== sv/conv3x3_shift_clamp_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef CONV3X3_SHIFT_CLAMP_MACROS_SVH
`define CONV3X3_SHIFT_CLAMP_MACROS_SVH

// same-cycle implication, off during reset
`define C3SC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c3sc check failed");

// next-cycle implication, off during reset
`define C3SC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c3sc check failed");

// next-cycle implication that also watches the reset cycles
`define C3SC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("c3sc check failed");

`endif

// ===== sv/c3sc_pkg.sv =====
package c3sc_pkg;

   localparam int PIX_W    = 8;
   localparam int LW_W     = 11;
   localparam int MTM_W    = 48;
   localparam int MB_W     = 24;
   localparam int SH_W     = 5;
   localparam int CSR_W    = 48;
   localparam int COEF_N   = 9;
   localparam int PROD_W   = 17;
   localparam int PSUM_W   = 19;
   localparam int SUM_W    = 21;
   localparam int PIX_MAX  = 255;
   localparam int OUT_DEPTH = 8;

   localparam logic [LW_W-1:0]  LW_RESET  = LW_W'(64);
   localparam logic [MTM_W-1:0] MTM_RESET = 48'h0001_0000_0000;

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_MASK_TOP_MID = 2'd1,
      CSR_MASK_BOTTOM  = 2'd2,
      CSR_SHIFT        = 2'd3
   } csr_index_type;

endpackage

// ===== sv/conv3x3_shift_clamp.sv =====
// 3x3 convolution over a raster pixel stream, with arithmetic shift and clamp to 0..255.
// req_*: one pixel per item, tuser[0] = frame start (restarts priming at this pixel).
// rsp_*: one convolution result per item once 2*W+3 pixels of the run have arrived.
// csr_*: register writes (line width, mask bytes, shift); write only while idle.
// Pipeline: a result reaches rsp_tvalid once its pixel has passed the line-store read,
// window, product, partial-sum and final-sum registers, then the output queue.
// Throughput: one pixel per clock while req_tready is high; each pixel reads and writes
// both line-store RAMs once, with forwarding when consecutive pixels hit one column.
// Results drain through an 8-entry output queue; req_tready drops when the queue
// plus the results still in the pipeline reach 8, so a stalled receiver stops
// intake after at most 8 pending results and nothing is lost.
// Reset (synchronous, active high): registers return to their defaults (width 64,
// identity mask, shift 0), priming restarts and the queue empties; the line stores
// are not cleared, priming keeps unwritten entries from being used.
// Writing line_width also restarts priming.
module conv3x3_shift_clamp #(
   parameter int MAX_LINE_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: [7:0] pixel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [c3sc_pkg::PIX_W-1:0]   req_tdata,
   // req_tuser: [0] frame_start
   input  logic [0:0]                   req_tuser,
   // rsp_tdata: [7:0] out_pixel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [c3sc_pkg::PIX_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  c3sc_pkg::csr_index_type      csr_index,
   input  logic [c3sc_pkg::CSR_W-1:0]   csr_data
);
   import c3sc_pkg::*;

   localparam int AW  = $clog2(MAX_LINE_WIDTH);
   localparam int WWR = $clog2(MAX_LINE_WIDTH + 1);
   localparam int WW  = (WWR > LW_W) ? WWR : LW_W;
   localparam int FW  = $clog2(2 * MAX_LINE_WIDTH + 4);
   localparam int OPW = $clog2(OUT_DEPTH);
   localparam int OCW = $clog2(OUT_DEPTH + 1);

   // configuration
   logic [LW_W-1:0]  line_width_ff;
   logic [MTM_W-1:0] mask_tm_ff;
   logic [MB_W-1:0]  mask_b_ff;
   logic [SH_W-1:0]  shift_ff;

   // line stores
   logic [PIX_W-1:0] lower_mem [MAX_LINE_WIDTH];
   logic [PIX_W-1:0] upper_mem [MAX_LINE_WIDTH];
   logic [PIX_W-1:0] rd_lo_ff, rd_up_ff;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_lo_ff, fwd_up_ff;

   // intake control
   logic [AW-1:0] colptr_ff, colptr_in, col_rd;
   logic [FW-1:0] fill_ff, fill_in, fill_base, need;
   logic [WW-1:0] w_eff, lw_ext, col_inc;
   logic          req_fire, rsp_fire, csr_fire, emit, fwd_in;

   // pipeline
   logic                     v1_ff, e1_ff, e2_ff, e3_ff, e4_ff, e5_ff;
   logic [AW-1:0]            col_ff;
   logic [PIX_W-1:0]         px_ff;
   logic [PIX_W-1:0]         d1, d2;
   logic [PIX_W-1:0]         win_ff [COEF_N];
   logic [COEF_N*PIX_W-1:0]  mask_all;
   logic signed [PROD_W-1:0] prod_ff [COEF_N];
   logic signed [PROD_W-1:0] prod_in [COEF_N];
   logic signed [PSUM_W-1:0] psum_ff [3];
   logic signed [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]         shifted;
   logic [PIX_W-1:0]         res_in;

   // output queue and credit
   logic [PIX_W-1:0] oq_mem [OUT_DEPTH];
   logic [OPW-1:0]   oq_wr_ff, oq_rd_ff;
   logic [OCW-1:0]   oq_cnt_ff, oq_cnt_in, credit_ff, credit_in;

   assign req_tready = !reset && (credit_ff < OCW'(OUT_DEPTH));
   assign csr_ready  = !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;

   // effective width, column and priming
   always_comb begin
      lw_ext = WW'(line_width_ff);
      if (lw_ext == '0) begin
         w_eff = WW'(1);
      end else if (lw_ext > WW'(MAX_LINE_WIDTH)) begin
         w_eff = WW'(MAX_LINE_WIDTH);
      end else begin
         w_eff = lw_ext;
      end
      need = (FW'(w_eff) << 1) + FW'(3);

      if (req_tuser[0] || (WW'(colptr_ff) >= w_eff)) begin
         col_rd = '0;
      end else begin
         col_rd = colptr_ff;
      end
      col_inc   = WW'(col_rd) + WW'(1);
      colptr_in = (col_inc >= w_eff) ? '0 : col_inc[AW-1:0];

      fill_base = req_tuser[0] ? '0 : fill_ff;
      fill_in   = (fill_base < need) ? fill_base + FW'(1) : fill_base;
      emit      = (fill_in >= need);

      // the pixel in stage 1 writes this same column at this edge
      fwd_in = v1_ff && (col_ff == col_rd);
   end

   assign d1 = fwd_ff ? fwd_lo_ff : rd_lo_ff;
   assign d2 = fwd_ff ? fwd_up_ff : rd_up_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_lo_ff <= lower_mem[col_rd];
         rd_up_ff <= upper_mem[col_rd];
      end
      if (v1_ff) begin
         lower_mem[col_ff] <= px_ff;
         upper_mem[col_ff] <= d1;
      end
   end

   // stage 1 payload and forwarding
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff     <= req_tdata;
         col_ff    <= col_rd;
         fwd_ff    <= fwd_in;
         fwd_lo_ff <= px_ff;
         fwd_up_ff <= d1;
      end
   end

   // window shift, products, adder tree
   assign mask_all = {mask_b_ff, mask_tm_ff};

   always_comb begin
      for (int i = 0; i < COEF_N; i++) begin
         prod_in[i] = PROD_W'($signed({1'b0, win_ff[i]}))
                    * PROD_W'($signed(mask_all[i*PIX_W +: PIX_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[3*r]   <= win_ff[3*r+1];
            win_ff[3*r+1] <= win_ff[3*r+2];
         end
         win_ff[2] <= d2;
         win_ff[5] <= d1;
         win_ff[8] <= px_ff;
      end
      for (int i = 0; i < COEF_N; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      for (int j = 0; j < 3; j++) begin
         psum_ff[j] <= PSUM_W'(prod_ff[3*j]) + PSUM_W'(prod_ff[3*j+1])
                     + PSUM_W'(prod_ff[3*j+2]);
      end
      sum_ff <= SUM_W'(psum_ff[0]) + SUM_W'(psum_ff[1]) + SUM_W'(psum_ff[2]);
   end

   // shift and clamp
   always_comb begin
      shifted = SUM_W'(sum_ff) >> shift_ff;
      if (sum_ff < 0) begin
         res_in = '0;
      end else if (shifted > SUM_W'(PIX_MAX)) begin
         res_in = PIX_W'(PIX_MAX);
      end else begin
         res_in = shifted[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (e5_ff) begin
         oq_mem[oq_wr_ff] <= res_in;
      end
   end

   assign rsp_tvalid = (oq_cnt_ff != '0);
   assign rsp_tdata  = oq_mem[oq_rd_ff];
   assign oq_cnt_in  = oq_cnt_ff + OCW'(e5_ff) - OCW'(rsp_fire);
   assign credit_in  = credit_ff + OCW'(req_fire && emit) - OCW'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LW_RESET;
         mask_tm_ff    <= MTM_RESET;
         mask_b_ff     <= '0;
         shift_ff      <= '0;
         colptr_ff     <= '0;
         fill_ff       <= '0;
         v1_ff         <= 1'b0;
         e1_ff         <= 1'b0;
         e2_ff         <= 1'b0;
         e3_ff         <= 1'b0;
         e4_ff         <= 1'b0;
         e5_ff         <= 1'b0;
         oq_wr_ff      <= '0;
         oq_rd_ff      <= '0;
         oq_cnt_ff     <= '0;
         credit_ff     <= '0;
      end else begin
         if (csr_fire) begin
            unique case (csr_index)
               CSR_LINE_WIDTH: begin
                  line_width_ff <= csr_data[LW_W-1:0];
                  colptr_ff     <= '0;
                  fill_ff       <= '0;
               end
               CSR_MASK_TOP_MID: mask_tm_ff <= csr_data[MTM_W-1:0];
               CSR_MASK_BOTTOM:  mask_b_ff  <= csr_data[MB_W-1:0];
               CSR_SHIFT:        shift_ff   <= csr_data[SH_W-1:0];
               default: ;
            endcase
         end else if (req_fire) begin
            colptr_ff <= colptr_in;
            fill_ff   <= fill_in;
         end
         v1_ff <= req_fire;
         e1_ff <= req_fire && emit;
         e2_ff <= e1_ff;
         e3_ff <= e2_ff;
         e4_ff <= e3_ff;
         e5_ff <= e4_ff;
         if (e5_ff) begin
            oq_wr_ff <= (oq_wr_ff == OPW'(OUT_DEPTH - 1)) ? '0 : oq_wr_ff + OPW'(1);
         end
         if (rsp_fire) begin
            oq_rd_ff <= (oq_rd_ff == OPW'(OUT_DEPTH - 1)) ? '0 : oq_rd_ff + OPW'(1);
         end
         oq_cnt_ff <= oq_cnt_in;
         credit_ff <= credit_in;
      end
   end

endmodule

// ===== sv/c3sc_checker.sv =====
`include "conv3x3_shift_clamp_macros.svh"

module c3sc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [c3sc_pkg::PIX_W-1:0] rsp_tdata
);
   import c3sc_pkg::*;

   logic req_fire;
   logic [PIX_W-1:0] rsp_hold;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_hold = rsp_tdata;

   // a result waiting on the receiver stays put
   `C3SC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_hold))

   // reset empties the output queue
   `C3SC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

   // with nothing queued and no pixel in the pipeline the block must take input
   `C3SC_ASSERT_NOW(a_idle_ready, clock, reset, !rsp_tvalid && !$past(req_fire, 1) && !$past(req_fire, 2) && !$past(req_fire, 3) && !$past(req_fire, 4) && !$past(req_fire, 5) && !$past(req_fire, 6) && !$past(reset, 1), req_tready)

endmodule

bind conv3x3_shift_clamp c3sc_checker u_c3sc_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
   import c3sc_pkg::*;

   localparam int MAX_W        = 1024;
   localparam int ITEM_TARGET  = 1740;
   localparam int DRAIN_CYCLES = 12;

   // Tracks line stores, window and registers; keeps the output pixels still due.
   class conv3x3_tracker;
      logic [PIX_W-1:0] upper_row [MAX_W];
      logic [PIX_W-1:0] lower_row [MAX_W];
      logic [PIX_W-1:0] window [COEF_N];
      int unsigned      col_ptr;
      int unsigned      fill;
      logic [LW_W-1:0]  width_reg;
      logic [MTM_W-1:0] mask_tm;
      logic [MB_W-1:0]  mask_b;
      logic [SH_W-1:0]  shift_reg;
      logic [PIX_W-1:0] out_pixels_due [$];
      int               errors;

      function new();
         width_reg = LW_RESET;
         mask_tm   = MTM_RESET;
         mask_b    = '0;
         shift_reg = '0;
         col_ptr   = 0;
         fill      = 0;
         errors    = 0;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_LINE_WIDTH: begin
               width_reg = value[LW_W-1:0];
               col_ptr   = 0;
               fill      = 0;
            end
            CSR_MASK_TOP_MID: mask_tm = value[MTM_W-1:0];
            CSR_MASK_BOTTOM:  mask_b = value[MB_W-1:0];
            CSR_SHIFT:        shift_reg = value[SH_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned row_len();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function void take_pixel(logic [PIX_W-1:0] px, logic frame_start);
         int unsigned      w;
         int unsigned      col;
         logic [PIX_W-1:0] one_up;
         logic [PIX_W-1:0] two_up;
         logic signed [7:0] coef;
         int               sum;
         int unsigned      scaled;
         int               k;
         w = row_len();
         if (frame_start) begin
            col_ptr = 0;
            fill    = 0;
         end
         if (col_ptr >= w) col_ptr = 0;
         col = col_ptr;
         one_up = lower_row[col];
         two_up = upper_row[col];
         upper_row[col] = one_up;
         lower_row[col] = px;
         col_ptr = (col + 1 >= w) ? 0 : col + 1;
         for (k = 0; k < 2; k++) begin
            window[k]     = window[k+1];
            window[3+k]   = window[4+k];
            window[6+k]   = window[7+k];
         end
         window[2] = two_up;
         window[5] = one_up;
         window[8] = px;
         if (fill < 2*w + 3) fill++;
         if (fill < 2*w + 3) return;
         sum = 0;
         for (k = 0; k < COEF_N; k++) begin
            coef = (k < 6) ? mask_tm[8*k +: 8] : mask_b[8*(k-6) +: 8];
            sum += int'(window[k]) * int'(coef);
         end
         if (sum < 0) begin
            out_pixels_due.push_back('0);
         end else begin
            scaled = sum >> shift_reg;
            out_pixels_due.push_back((scaled > PIX_MAX) ? PIX_W'(PIX_MAX) : scaled[PIX_W-1:0]);
         end
      endfunction

      function void match_result(logic [PIX_W-1:0] got);
         logic [PIX_W-1:0] want;
         if (out_pixels_due.size() == 0) begin
            $error("out_pixel: expected none, actual %0d", got);
            errors++;
            return;
         end
         want = out_pixels_due.pop_front();
         if (got !== want) begin
            $error("out_pixel: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction

      function int pending();
         return out_pixels_due.size();
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PIX_W-1:0]    req_tdata = '0;
   logic [0:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [PIX_W-1:0]    rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_LINE_WIDTH;
   logic [CSR_W-1:0]    csr_data = '0;

   conv3x3_tracker tracker = new();
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   int long_hold_cycles = 0;

   conv3x3_shift_clamp #(.MAX_LINE_WIDTH(MAX_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_pixel(logic [PIX_W-1:0] px, logic fs);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_pixel(px, fs);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering pixels and wait for every due result; optionally let the pipe empty
   task automatic wait_drained(bit pipe_empty);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      if (pipe_empty) repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic pick_masks();
      logic [MTM_W-1:0] tm;
      logic [MB_W-1:0]  bm;
      logic [7:0]       c;
      int               mode;
      int               sh;
      int               k;
      mode = $urandom_range(0, 2);
      for (k = 0; k < COEF_N; k++) begin
         case (mode)
            0: c = 8'($urandom_range(0, 255));
            1: c = 8'($urandom_range(0, 6)) - 8'd3;
            default: c = 8'($urandom_range(0, 8));
         endcase
         if (k < 6) tm[8*k +: 8] = c;
         else bm[8*(k-6) +: 8] = c;
      end
      case (mode)
         0: sh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(6, 14);
         1: sh = $urandom_range(0, 3);
         default: sh = $urandom_range(2, 6);
      endcase
      write_reg(CSR_MASK_TOP_MID, CSR_W'(tm));
      write_reg(CSR_MASK_BOTTOM, CSR_W'(bm));
      write_reg(CSR_SHIFT, CSR_W'(sh));
   endtask

   task automatic stream_pixels(int count, int pause_at);
      logic [PIX_W-1:0] px;
      logic             fs;
      int               n;
      for (n = 0; n < count; n++) begin
         if (n == pause_at) wait_drained(1'b0);
         if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else px = 8'($urandom_range(0, 255));
         fs = ($urandom_range(0, 79) == 0);
         send_pixel(px, fs);
      end
   endtask

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         if (long_hold_cycles > 0) begin
            gap = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            gap = receiver_steady ? 0 : $urandom_range(0, 7);
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         tracker.match_result(rsp_tdata);
      end
   end

   initial begin
      logic [PIX_W-1:0] ramp [7];
      int random_items;
      int phase_no;
      int w;
      int eff;
      int count;
      int pause_at;
      int r;
      ramp = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1, 8'd128, 8'd254};
      random_items = 0;
      phase_no = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset mask and shift (center tap only), narrowest row
      write_reg(CSR_LINE_WIDTH, CSR_W'(1));
      foreach (ramp[i]) send_pixel(ramp[i], 1'b0);
      wait_drained(1'b1);

      // all taps +127: saturates high; zero width behaves as one; restart mid-stream
      write_reg(CSR_MASK_TOP_MID, 48'h7F7F_7F7F_7F7F);
      write_reg(CSR_MASK_BOTTOM, CSR_W'(24'h7F7F7F));
      write_reg(CSR_SHIFT, CSR_W'(0));
      write_reg(CSR_LINE_WIDTH, CSR_W'(0));
      repeat (6) send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b1);
      repeat (4) send_pixel(8'h00, 1'b0);
      wait_drained(1'b1);

      // all taps -128 and the widest shift: negative sum clamps to zero
      write_reg(CSR_MASK_TOP_MID, 48'h8080_8080_8080);
      write_reg(CSR_MASK_BOTTOM, CSR_W'(24'h808080));
      write_reg(CSR_SHIFT, CSR_W'(31));
      write_reg(CSR_LINE_WIDTH, CSR_W'(2));
      repeat (8) send_pixel(8'hFF, 1'b0);
      wait_drained(1'b1);

      while (random_items < ITEM_TARGET) begin
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 19);
         if (r == 0) w = 0;
         else if (r < 12) w = $urandom_range(1, 4);
         else if (r < 18) w = $urandom_range(5, 16);
         else w = $urandom_range(17, 64);
         eff = (w == 0) ? 1 : w;
         count = 2*eff + 3 + $urandom_range(10, 120);
         if (phase_no == 1) begin
            // fill the output queue: receiver holds off while pixels keep coming
            sender_steady = 1'b1;
            w = $urandom_range(1, 4);
            count = 2*w + 3 + 260;
         end
         pick_masks();
         write_reg(CSR_LINE_WIDTH, CSR_W'(w));
         if (phase_no == 1) long_hold_cycles = 150;
         pause_at = (phase_no == 0 || $urandom_range(0, 3) == 0) ? count / 2 : -1;
         stream_pixels(count, pause_at);
         wait_drained(1'b1);
         random_items += count;
         phase_no++;
      end

      // oversized width saturates to the full line store; far too short to prime
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      pick_masks();
      write_reg(CSR_LINE_WIDTH, CSR_W'(2047));
      stream_pixels(64, -1);
      wait_drained(1'b1);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== conv3x3_shift_clamp.f =====
+incdir+sv
sv/c3sc_pkg.sv
sv/conv3x3_shift_clamp.sv
sv/c3sc_checker.sv
verif/tb_top.sv
